// ===== rtl/core/utli_pkg.sv =====
// shared types and constants for the uniform table linear interpolator
// depends on nothing; imported by utli_mem, utli_query and the top level
`default_nettype none

package utli_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // command codes carried in tuser of the input channel
    localparam logic [1:0] CMD_LOAD_FIRST = 2'd0;
    localparam logic [1:0] CMD_LOAD_NEXT  = 2'd1;
    localparam logic [1:0] CMD_QUERY      = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_START_X     = 2'd0;
    localparam logic [1:0] CFG_INV_SPACING = 2'd1;
    localparam logic [1:0] CFG_EDGE_POLICY = 2'd2;

    // one table entry: base value and signed slope to the next sample
    typedef struct packed {
        logic signed [32:0] slope;
        logic signed [31:0] base;
    } t_entry;

    // table bookkeeping seen by the query path
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic signed [31:0] tail_sample;
        logic signed [31:0] first_base;
    } t_tbl_status;

    // configuration seen by the query path
    typedef struct packed {
        logic signed [31:0] start_x;
        logic [31:0]        inv_spacing;
        logic               edge_policy;
    } t_query_cfg;

    // query sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_READ,
        S_PROD,
        S_SUM
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/uniform_table_linear_interp.sv =====
// top level of the uniform table linear interpolator: channels, config, table loading
// depends on utli_pkg, utli_mem and utli_query
//
// usage
//   input channel: tuser holds the command, tdata holds sample value and position.
//   load-first clears the table and keeps the sample; each load-next appends one
//   entry (previous sample and its difference to the new one). loads beyond
//   1024 entries are ignored. loads and unused commands give no output item.
//   a query gives one output item: tdata is the result, tuser the outside flag.
// query sequence
//   a load does not drop ready. a query result is loaded into the output
//   register in steps: offset at acceptance, then 32x32 scale multiply, memory
//   read, fraction times slope multiply, sum and edge select. one query is in
//   flight at a time and ready returns as the result is loaded.
// reset and stall
//   reset empties the table and sets start 0, spacing 1.0, edge extension on.
//   memory contents are not cleared. the output register holds a result while
//   the receiver stalls; a new item is accepted meanwhile and a following query
//   waits in its last step until the register is free.
//   configuration must be written only while no query is in flight; not enforced.
`default_nettype none

module uniform_table_linear_interp
    import utli_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    // input channel
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // [31:0] sample_value, [63:32] position
    input  wire logic [1:0]  i_s_tuser,   // [1:0] cmd
    // output channel
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] result
    output logic [0:0]       o_m_tuser    // [0] outside
);

    logic signed [31:0] r_start_x;
    logic [31:0]        r_inv_spacing;
    logic               r_edge_policy;
    logic [CNT_W-1:0]   r_count;
    logic signed [31:0] r_prev;
    logic signed [31:0] r_first_base;

    logic               w_accept;
    logic [1:0]         w_cmd;
    logic signed [31:0] w_value;
    logic signed [31:0] w_position;
    logic               w_load_next;
    logic               w_start;
    logic               w_busy;
    t_entry             w_wr_data;
    t_entry             w_rd_data;
    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    t_query_cfg         w_cfg;
    t_tbl_status        w_status;
    logic signed [31:0] w_result;
    logic               w_outside;

    assign o_s_tready = !w_busy;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_cmd      = i_s_tuser;
    assign w_value    = i_s_tdata[31:0];
    assign w_position = i_s_tdata[63:32];

    // command decode
    always_comb begin
        w_load_next = 1'b0;
        w_start     = 1'b0;
        case (w_cmd)
            CMD_LOAD_NEXT: w_load_next = w_accept && (r_count < CNT_W'(TABLE_DEPTH));
            CMD_QUERY:     w_start     = w_accept;
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x     <= '0;
            r_inv_spacing <= 32'h0001_0000;
            r_edge_policy <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_START_X:     r_start_x     <= i_cfg_wdata;
                CFG_INV_SPACING: r_inv_spacing <= i_cfg_wdata;
                CFG_EDGE_POLICY: r_edge_policy <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // table bookkeeping: entry count, previous sample, base of the first entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= '0;
        end else if (w_accept && w_cmd == CMD_LOAD_FIRST) begin
            r_count <= '0;
            r_prev  <= w_value;
        end else if (w_load_next) begin
            r_count <= r_count + 1'b1;
            r_prev  <= w_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_next && r_count == '0) begin
            r_first_base <= r_prev;
        end
    end

    // new entry written at the current count
    assign w_wr_data.base  = r_prev;
    assign w_wr_data.slope = 33'(w_value) - 33'(r_prev);

    assign w_cfg.start_x     = r_start_x;
    assign w_cfg.inv_spacing = r_inv_spacing;
    assign w_cfg.edge_policy = r_edge_policy;

    assign w_status.count       = r_count;
    assign w_status.tail_sample = r_prev;
    assign w_status.first_base  = r_first_base;

    utli_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_load_next),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    utli_query u_query (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_position  (w_position),
        .i_cfg       (w_cfg),
        .i_status    (w_status),
        .o_busy      (w_busy),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_result  (w_result),
        .o_m_outside (w_outside)
    );

    assign o_m_tdata    = w_result;
    assign o_m_tuser[0] = w_outside;

    // the entry count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // a table write never overlaps a query in flight
    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_next |-> !w_busy)
        else $error("table write during a query");

    // an accepted query holds off the input until it is done
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_s_tready)
        else $error("input ready right after a query was accepted");

    // a stalled output item stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("output item changed while stalled");

endmodule

`default_nettype wire

// ===== rtl/core/utli_mem.sv =====
// entry memory: one write port, one read port with registered read data
// depends on utli_pkg for the table depth and the entry type
`default_nettype none

module utli_mem
    import utli_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire t_entry           i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_entry                o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/utli_query.sv =====
// query sequencer: offset, scale, table read, fraction multiply, sum, output register
// depends on utli_pkg; reads the entry memory through its read port
`default_nettype none

module utli_query
    import utli_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_position,
    input  wire t_query_cfg         i_cfg,
    input  wire t_tbl_status        i_status,
    output logic                    o_busy,
    output logic                    o_rd_en,
    output logic [IDX_W-1:0]        o_rd_addr,
    input  wire t_entry             i_rd_data,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic signed [31:0]      o_m_result,
    output logic                    o_m_outside
);

    t_state r_state, n_state;

    logic signed [32:0] r_offset;
    logic [63:0]        r_scaled;
    logic               r_before;
    logic               r_past;
    logic signed [49:0] r_prod;
    logic signed [31:0] r_base;
    logic               r_m_valid;
    logic signed [31:0] r_m_result;
    logic               r_m_outside;

    logic               w_out_load;
    logic signed [49:0] w_prod_sh;
    logic signed [31:0] w_sum;
    logic signed [31:0] w_edge;
    logic               w_has_entries;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_READ;
            S_READ: n_state = S_PROD;
            S_PROD: n_state = S_SUM;
            S_SUM: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_busy     = 1'b1;
        o_rd_en    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: o_busy = 1'b0;
            S_READ: o_rd_en = 1'b1;
            S_SUM:  w_out_load = !r_m_valid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // offset from the domain start, sign bit marks a position before the start
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_offset <= 33'(i_position) - 33'(i_cfg.start_x);
        end
    end

    // scale by the reciprocal spacing into index and fraction
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_scaled <= 64'(r_offset[31:0]) * 64'(i_cfg.inv_spacing);
            r_before <= r_offset[32];
        end
    end

    assign o_rd_addr = r_scaled[32 +: IDX_W];

    // index range check beside the table read
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_past <= r_scaled[63:32] >= 32'(i_status.count);
        end
    end

    // fraction times slope
    always_ff @(posedge i_clk) begin
        if (r_state == S_PROD) begin
            r_prod <= $signed({1'b0, r_scaled[31:16]}) * i_rd_data.slope;
            r_base <= i_rd_data.base;
        end
    end

    // floor of the product over 2^16 added to the base
    assign w_prod_sh     = r_prod >>> 16;
    assign w_sum         = r_base + w_prod_sh[31:0];
    assign w_has_entries = i_status.count != '0;

    // edge value for positions outside the domain
    always_comb begin
        w_edge = '0;
        if (i_cfg.edge_policy && w_has_entries) begin
            w_edge = r_before ? i_status.first_base : i_status.tail_sample;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_outside <= r_before || r_past;
            r_m_result  <= (r_before || r_past) ? w_edge : w_sum;
        end
    end

    assign o_m_tvalid  = r_m_valid;
    assign o_m_result  = r_m_result;
    assign o_m_outside = r_m_outside;

endmodule

`default_nettype wire

// ===== bench/uniform_table_linear_interp_tb.sv =====
// self-checking testbench for uniform_table_linear_interp: table loads, queries, edge policies
// depends on utli_pkg and the rtl top level; a scoreboard class holds its own table and config
`timescale 1ns / 100ps

module uniform_table_linear_interp_tb
    import utli_pkg::*;
();

    localparam int    PERIOD_HALF = 10;
    localparam int    RESET_CYCLES = 4;
    localparam int    CYCLE_LIMIT = 800000;
    localparam int    HOLD_CYCLES = 300;
    localparam int    SETTLE_CYCLES = 8;
    localparam int    RANDOM_PHASES = 12;
    localparam int    PHASE_ITEMS = 46;
    localparam int    FILL_LOADS = 40;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam longint POS_MAX = 64'sd2147483647;

    // command code with no function
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one expected output item
    typedef struct {
        logic [31:0] result;
        logic        outside;
    } t_interp_result;

    // predicts the interpolated output from its own copy of table and config
    class interp_checker;
        logic signed [31:0] base_tbl [TABLE_DEPTH];
        logic signed [32:0] slope_tbl [TABLE_DEPTH];
        int unsigned        n_entries;
        logic signed [31:0] prev_sample;
        logic signed [31:0] start_x;
        logic [31:0]        inv_spacing;
        logic               edge_policy;
        t_interp_result     pending_results [$];
        int unsigned        n_loads;
        int unsigned        n_ignored;
        int unsigned        n_queries;
        int unsigned        n_outside;
        int unsigned        n_unused;
        int unsigned        n_checked;
        int unsigned        n_settings;
        int unsigned        failures;

        function new();
            n_entries   = 0;
            prev_sample = '0;
            start_x     = '0;
            inv_spacing = 32'h0001_0000;
            edge_policy = 1'b1;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] data);
            n_settings++;
            case (index)
                CFG_START_X:     start_x = data;
                CFG_INV_SPACING: inv_spacing = data;
                CFG_EDGE_POLICY: edge_policy = data[0];
                default: ;
            endcase
        endfunction

        // value and outside flag for one query position
        function t_interp_result interpolate(logic signed [31:0] pos);
            t_interp_result r;
            longint         offset;
            longint         prod;
            logic [63:0]    scaled;
            int unsigned    idx;
            logic [15:0]    frac;
            r.result  = '0;
            r.outside = 1'b1;
            if (pos < start_x) begin
                if (edge_policy && n_entries != 0)
                    r.result = base_tbl[0];
            end else begin
                offset = longint'(pos) - longint'(start_x);
                scaled = {32'b0, offset[31:0]} * {32'b0, inv_spacing};
                if (scaled[63:32] >= n_entries) begin
                    if (edge_policy && n_entries != 0)
                        r.result = base_tbl[n_entries-1] + slope_tbl[n_entries-1];
                end else begin
                    idx       = scaled[63:32];
                    frac      = scaled[31:16];
                    prod      = longint'($signed({1'b0, frac})) * longint'(slope_tbl[idx]);
                    r.result  = 32'(longint'(base_tbl[idx]) + (prod >>> 16));
                    r.outside = 1'b0;
                end
            end
            if (r.outside)
                n_outside++;
            return r;
        endfunction

        // one accepted input item
        function void take_item(logic [1:0] cmd, logic signed [31:0] value,
                                logic signed [31:0] pos);
            case (cmd)
                CMD_LOAD_FIRST: begin
                    n_loads++;
                    n_entries   = 0;
                    prev_sample = value;
                end
                CMD_LOAD_NEXT: begin
                    n_loads++;
                    if (n_entries < TABLE_DEPTH) begin
                        base_tbl[n_entries]  = prev_sample;
                        slope_tbl[n_entries] = value - prev_sample;
                        n_entries++;
                        prev_sample = value;
                    end else begin
                        n_ignored++;
                    end
                end
                CMD_QUERY: begin
                    n_queries++;
                    pending_results = {pending_results, interpolate(pos)};
                end
                default: n_unused++;
            endcase
        endfunction

        // one accepted output item against the oldest expectation
        function void check_result(logic [31:0] result, logic outside);
            t_interp_result e;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected output item: result %h outside %b", result, outside);
                return;
            end
            e = pending_results.pop_front();
            n_checked++;
            if (result !== e.result || outside !== e.outside) begin
                failures++;
                if (failures <= 10)
                    $display("output item %0d differs:%s%s expected %h/%b got %h/%b",
                             n_checked, (result !== e.result) ? " result" : "",
                             (outside !== e.outside) ? " outside" : "",
                             e.result, e.outside, result, outside);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_START_X;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_LOAD_FIRST;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    interp_checker table_check = new();
    bit          idling_on = 1'b1;
    bit          sender_gaps = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned cycle_count = 0;

    uniform_table_linear_interp u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),   // [31:0] sample_value, [63:32] position
        .i_s_tuser   (s_tuser),   // [1:0] cmd
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),   // [31:0] result
        .o_m_tuser   (m_tuser)    // [0] outside
    );

    // 20 ns clock
    always begin
        #PERIOD_HALF clk = 1'b1;
        #PERIOD_HALF clk = 1'b0;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // idle length: mostly none or short, a few long
    function automatic int pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: check accepted items, stall at random or on a hold request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                table_check.check_result(m_tdata, m_tuser[0]);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = pick_idle();
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one item and wait for its acceptance
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] value,
                             input logic [31:0] pos);
        int gap;
        gap = sender_gaps ? pick_idle() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pos, value};
        do @(posedge clk); while (!s_tready);
        table_check.take_item(cmd, value, pos);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (table_check.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three registers while nothing is in flight
    task automatic set_config(input logic [31:0] sx, input logic [31:0] inv, input logic pol);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START_X;
        cfg_wdata <= sx;
        @(posedge clk);
        table_check.write_reg(CFG_START_X, sx);
        cfg_index <= CFG_INV_SPACING;
        cfg_wdata <= inv;
        @(posedge clk);
        table_check.write_reg(CFG_INV_SPACING, inv);
        cfg_index <= CFG_EDGE_POLICY;
        cfg_wdata <= {31'b0, pol};
        @(posedge clk);
        table_check.write_reg(CFG_EDGE_POLICY, {31'b0, pol});
        cfg_wr_en <= 1'b0;
    endtask

    // query position: mostly inside the table, some before, past or random
    function automatic logic [31:0] pick_position();
        longint      sx;
        longint      want;
        longint      offset;
        int unsigned n;
        int unsigned r;
        sx   = longint'(table_check.start_x);
        n    = table_check.n_entries;
        r    = $urandom_range(0, 99);
        want = -1;
        if (r < 55 && n != 0) begin
            want = (longint'($urandom_range(0, n - 1)) << 32) | longint'($urandom);
        end else if (r < 70) begin
            want = (longint'(n + $urandom_range(0, 2)) << 32) | longint'($urandom);
        end else if (r < 82) begin
            offset = sx - 1 - longint'($urandom_range(0, 4095));
            if (offset >= POS_MIN)
                return 32'(offset);
        end else if (r < 87) begin
            return 32'(sx);
        end
        if (want >= 0) begin
            offset = want / longint'(table_check.inv_spacing);
            if (offset <= 64'sh0000_0000_FFFF_FFFF && sx + offset <= POS_MAX)
                return 32'(sx + offset);
        end
        return $urandom;
    endfunction

    // one random item with weighted command choice
    task automatic send_random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4)
            send_item(CMD_LOAD_FIRST, $urandom, $urandom);
        else if (r < 20)
            send_item(CMD_LOAD_NEXT, $urandom, $urandom);
        else if (r < 24)
            send_item(CMD_UNUSED, $urandom, $urandom);
        else
            send_item(CMD_QUERY, $urandom, pick_position());
    endtask

    initial begin
        logic [31:0] dir_load [5];
        logic [31:0] dir_pos [9];
        logic [31:0] sx;
        logic [31:0] inv;
        int          n_load;

        dir_load = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        dir_pos  = '{32'h0000_0000, 32'h0000_FFFF, 32'h0001_8000, 32'h0002_FFFF, 32'h0003_0001,
                     32'h0004_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};

        // reset
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load entries without a first load, then query around the table end
        for (int i = 0; i < FILL_LOADS; i++)
            send_item(CMD_LOAD_NEXT, $urandom, $urandom);
        for (int i = 0; i < 12; i++)
            send_item(CMD_QUERY, $urandom,
                      32'(($urandom_range(FILL_LOADS - 6, FILL_LOADS + 5) << 16)
                          | $urandom_range(0, 65535)));

        // directed: extreme samples and slopes, rounding, both edges, unused command
        set_config(32'h0, 32'h0001_0000, 1'b1);
        send_item(CMD_LOAD_FIRST, dir_load[0], 32'h0);
        for (int i = 1; i < 5; i++)
            send_item(CMD_LOAD_NEXT, dir_load[i], 32'hFFFF_FFFF);
        foreach (dir_pos[i])
            send_item(CMD_QUERY, 32'hFFFF_FFFF, dir_pos[i]);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // outside the domain gives zero
        set_config(32'h0, 32'h0001_0000, 1'b0);
        send_item(CMD_QUERY, 32'h0, 32'hFFFF_0000);
        send_item(CMD_QUERY, 32'h0, 32'h0005_0000);

        // empty table
        set_config(32'h0, 32'h0001_0000, 1'b1);
        send_item(CMD_LOAD_FIRST, 32'h1234_5678, 32'h0);
        send_item(CMD_QUERY, 32'h0, 32'h0000_0000);
        send_item(CMD_QUERY, 32'h0, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 32'h0, 32'h0010_0000);

        // random phases, the first four at extreme settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin sx = 32'h8000_0000; inv = 32'h0001_0000; end
                1: begin sx = 32'h7FFF_FFFF; inv = 32'hFFFF_FFFF; end
                2: begin sx = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20); inv = 32'd1; end
                3: begin sx = 32'h0; inv = 32'hFFFF_FFFF; end
                default: begin
                    sx = ($urandom_range(0, 3) == 0) ? $urandom
                         : 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
                    case ($urandom_range(0, 4))
                        0: inv = 32'h0001_0000;
                        1: inv = $urandom_range(1 << 12, 1 << 20);
                        2: inv = $urandom_range(1 << 20, 1 << 28);
                        3: inv = $urandom_range(1, 32'hFFFF_FFFF);
                        default: inv = 32'($urandom_range(1, 8)) << 16;
                    endcase
                end
            endcase
            set_config(sx, inv, (ph == 1) ? 1'b0 : (ph < 4) ? 1'b1 : 1'($urandom_range(0, 1)));
            idling_on = (ph % 4 != 3);

            // mostly a fresh small table, now and then a larger one
            if ($urandom_range(0, 7) != 0) begin
                n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                         : $urandom_range(0, 10);
                send_item(CMD_LOAD_FIRST, $urandom, $urandom);
                for (int i = 0; i < n_load; i++)
                    send_item(CMD_LOAD_NEXT, $urandom, $urandom);
            end

            // long output stall while queries keep coming
            if (ph == 5) begin
                hold_request = 1'b1;
                sender_gaps  = 1'b0;
                for (int i = 0; i < 16; i++)
                    send_item(CMD_QUERY, $urandom, pick_position());
                sender_gaps = 1'b1;
            end

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < 3)
                    wait_results();
                send_random_item();
            end
        end

        // drain and report
        idling_on = 1'b1;
        wait_idle();
        table_check.failures += table_check.pending_results.size();
        $display("covered %0d loads (%0d into a full table), %0d queries (%0d outside), %0d unused",
                 table_check.n_loads, table_check.n_ignored, table_check.n_queries,
                 table_check.n_outside, table_check.n_unused);
        $display("%0d register writes, %0d output items checked, %0d failures",
                 table_check.n_settings, table_check.n_checked, table_check.failures);
        if (table_check.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/utli_pkg.sv
rtl/core/utli_mem.sv
rtl/core/utli_query.sv
rtl/core/uniform_table_linear_interp.sv
bench/uniform_table_linear_interp_tb.sv
